// ===== src/phpd_pkg.sv =====
// Pixel hit position decoder: shared types, decode constants and module alignment tables.
// No dependencies.
`timescale 1ns / 1ps

package phpd_pkg;

	// Lengths in units of 1e-5 cm, two's complement, one bit wider than the ports
	typedef logic signed [23:0] pos_t;

	// Partition and front end split out of the millions digit group
	typedef struct packed {
		logic [1:0] part;
		logic [3:0] fe;
	} id_split_t;

	// Identifier decode
	localparam int unsigned DEC_STEP  = 1000000;  // one front end step in the id
	localparam int unsigned DEC_MAX_Q = 33;       // largest id / 10^6 in 25 bits
	localparam logic [20:0] ROW_RECIP = 21'd1073742; // ceil(2^30 / 1000)
	localparam int unsigned ROW_SHIFT = 30;
	localparam logic [19:0] ROW_DIV   = 20'd1000;

	// Pixel geometry, units of 1e-5 cm
	localparam logic [23:0] COL_PITCH = 24'd2500;
	localparam logic [23:0] EDGE_HALF = 24'd2250;
	localparam logic [23:0] ROW_TOP   = 24'd167750;
	localparam logic [23:0] ROW_PITCH = 24'd500;

	// Per-module terms: position = local + OFS, where OFS already holds the
	// negated alignment offset and the round-to-nearest (ties up) correction.
	localparam pos_t OFS_X [16] = '{
		-24'sd69920, -24'sd61061, -24'sd70348, -24'sd70358,
		-24'sd70431, -24'sd61495, -24'sd68615, -24'sd69723,
		-24'sd73643, -24'sd62413, -24'sd68630, -24'sd67493,
		24'sd0, 24'sd0, 24'sd0, 24'sd0
	};
	localparam pos_t OFS_Y [16] = '{
		24'sd238, -24'sd554, 24'sd3060, 24'sd3799,
		24'sd232, 24'sd2163, 24'sd6703, 24'sd3097,
		-24'sd114, -24'sd696, -24'sd1550, -24'sd4918,
		24'sd0, 24'sd0, 24'sd0, 24'sd0
	};
	localparam pos_t Z_REF [16] = '{
		-24'sd13000, 24'sd52000, 24'sd241200, 24'sd309000,
		24'sd510000, 24'sd579000, 24'sd779000, 24'sd846000,
		24'sd1046200, 24'sd1117000, 24'sd1316200, 24'sd1385000,
		24'sd0, 24'sd0, 24'sd0, 24'sd0
	};

	// id / 10^6 (0..33) into partition (tens) and front end (units)
	function automatic id_split_t split_q(input logic [5:0] q);
		id_split_t s;
		s.part = (q >= 6'd30) ? 2'd3 : (q >= 6'd20) ? 2'd2 : (q >= 6'd10) ? 2'd1 : 2'd0;
		s.fe   = 4'(q - 6'(s.part) * 6'd10);
		return s;
	endfunction

endpackage

// ===== src/pixel_hit_position_decoder.sv =====
// Pixel hit position decoder top level: four-register pipeline from hit id to position.
// Depends on phpd_pkg for constants, alignment tables and the id split function.
`timescale 1ns / 1ps

// Usage
//   Hit channel: detector_id with hit_valid / hit_ready. One decimal-packed id per transfer.
//   Result channel: decoded fields, x/y/z position and valid_res with res_valid / res_ready.
//   Every hit gives exactly one result, in order.
// Throughput: one hit per clock. Each stage moves whenever the stage after it is empty
//   or moving, so bubbles close up and a new hit is taken in every cycle the result
//   side keeps up.
// Stages: stage 1 splits off id / 10^6, stage 2 forms the row with a reciprocal multiply,
//   stage 3 forms the column and range checks, the output register holds the
//   position.
// Stall: while res_ready is low the result holds; the stages behind it keep filling,
//   and hit_ready drops only once all four registers hold a result.
// Reset: arst_n clears all stage valid bits; the pipeline comes up empty and ready.
// Out-of-range ids still report their decoded fields, with valid_res low and a zero
//   position.
module pixel_hit_position_decoder #(
	parameter int NUM_MODULES   = 12,
	parameter int ROWS_PER_CHIP = 336,
	parameter int COLS_PER_CHIP = 80
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               hit_valid,
	output logic               hit_ready,
	input  logic        [24:0] detector_id,
	output logic               res_valid,
	input  logic               res_ready,
	output logic        [1:0]  partition,
	output logic        [2:0]  front_end,
	output logic        [3:0]  module_index,
	output logic        [9:0]  pixel_row,
	output logic        [10:0] module_column,
	output logic signed [22:0] x_pos,
	output logic signed [22:0] y_pos,
	output logic signed [22:0] z_pos,
	output logic               valid_res
);

	localparam logic [9:0] ROWS_LIM = 10'(ROWS_PER_CHIP);
	localparam logic [9:0] COLS_LIM = 10'(COLS_PER_CHIP);
	localparam logic [4:0] MODS_LIM = 5'(NUM_MODULES);

	// Stage valid bits and flow control
	logic v_s1, v_s2, v_s3, res_valid_q;
	logic rdy_out, rdy_s3, rdy_s2;

	assign rdy_out   = !res_valid_q || res_ready;
	assign rdy_s3    = !v_s3 || rdy_out;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign hit_ready = !v_s1 || rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (hit_ready) v_s1 <= hit_valid;
			if (rdy_s2)    v_s2 <= v_s1;
			if (rdy_s3)    v_s3 <= v_s2;
			if (rdy_out)   res_valid_q <= v_s3;
		end
	end

	// Stage 1: find id / 10^6 by comparing against every multiple, keep the remainder
	logic [5:0]  q_d;
	logic [24:0] base_d;
	logic [5:0]  q_s1;
	logic [19:0] rem_s1;

	always_comb begin
		q_d    = '0;
		base_d = '0;
		for (int k = 1; k <= phpd_pkg::DEC_MAX_Q; k++) begin
			if (detector_id >= 25'(k * phpd_pkg::DEC_STEP)) begin
				q_d    = 6'(k);
				base_d = 25'(k * phpd_pkg::DEC_STEP);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit_ready) begin
			q_s1   <= q_d;
			rem_s1 <= 20'(detector_id - base_d);
		end
	end

	// Stage 2: partition / front end from the quotient, row = rem / 1000 by reciprocal
	phpd_pkg::id_split_t split_d;
	logic [40:0] row_prod;
	logic [1:0]  part_s2;
	logic [3:0]  fe_s2;
	logic [9:0]  row_s2;
	logic [19:0] rem_s2;

	assign split_d  = phpd_pkg::split_q(q_s1);
	assign row_prod = 41'(rem_s1) * 41'(phpd_pkg::ROW_RECIP);

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			part_s2 <= split_d.part;
			fe_s2   <= split_d.fe;
			row_s2  <= row_prod[phpd_pkg::ROW_SHIFT +: 10];
			rem_s2  <= rem_s1;
		end
	end

	// Stage 3: column, module, stitched column and range checks
	logic [19:0] col_full;
	logic [9:0]  col_d;
	logic [4:0]  mod_d;
	logic        valid_d;
	logic [1:0]  part_s3;
	logic [3:0]  fe_s3;
	logic [4:0]  mod_s3;
	logic [9:0]  row_s3;
	logic [9:0]  col_s3;
	logic [10:0] mcol_s3;
	logic        valid_s3;

	assign col_full = rem_s2 - 20'(row_s2) * phpd_pkg::ROW_DIV;
	assign col_d    = col_full[9:0];
	assign mod_d    = {1'b0, part_s2, 2'b00} + 5'(fe_s2[3:1]);
	assign valid_d  = (part_s2 != 2'd3) && (fe_s2 <= 4'd7) &&
			(row_s2 != 10'd0) && (row_s2 <= ROWS_LIM) &&
			(col_d != 10'd0) && (col_d <= COLS_LIM) && (mod_d < MODS_LIM);

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			part_s3  <= part_s2;
			fe_s3    <= fe_s2;
			mod_s3   <= mod_d;
			row_s3   <= row_s2;
			col_s3   <= col_d;
			mcol_s3  <= 11'(col_d) + (fe_s2[0] ? 11'd0 : 11'(COLS_PER_CHIP));
			valid_s3 <= valid_d;
		end
	end

	// Output stage: local position, front end orientation, module offsets
	logic [9:0]  col_steps;
	logic        edge_col;
	logic [23:0] col_mag;
	logic [23:0] xl, yl, gx, gy, xg, yg;

	assign col_steps = fe_s3[0] ? (COLS_LIM - col_s3) : (col_s3 - 10'd1);
	assign edge_col  = (col_s3 == COLS_LIM);
	assign col_mag   = 24'(col_steps) * phpd_pkg::COL_PITCH;

	always_comb begin
		// Odd front ends count columns leftward from the edge, even ones rightward
		if (fe_s3[0]) begin
			xl = 24'd0 - col_mag - (edge_col ? phpd_pkg::EDGE_HALF : 24'd0);
		end else begin
			xl = col_mag + phpd_pkg::EDGE_HALF + (edge_col ? phpd_pkg::COL_PITCH : 24'd0);
		end
		yl = phpd_pkg::ROW_TOP - 24'(row_s3 - 10'd1) * phpd_pkg::ROW_PITCH;
		case (fe_s3) inside
			4'd0, 4'd1: begin
				gx = 24'd0 - yl;
				gy = xl;
			end
			4'd2, 4'd3: begin
				gx = yl;
				gy = xl;
			end
			4'd4, 4'd5: begin
				gx = 24'd0 - xl;
				gy = 24'd0 - yl;
			end
			default: begin
				gx = 24'd0 - xl;
				gy = yl;
			end
		endcase
		xg = gx + phpd_pkg::OFS_X[mod_s3[3:0]];
		yg = gy + phpd_pkg::OFS_Y[mod_s3[3:0]];
	end

	logic [1:0]         partition_q;
	logic [2:0]         front_end_q;
	logic [3:0]         module_index_q;
	logic [9:0]         pixel_row_q;
	logic [10:0]        module_column_q;
	logic signed [22:0] x_pos_q, y_pos_q, z_pos_q;
	logic               valid_res_q;

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			partition_q     <= part_s3;
			front_end_q     <= fe_s3[2:0];
			module_index_q  <= mod_s3[3:0];
			pixel_row_q     <= row_s3;
			module_column_q <= mcol_s3;
			valid_res_q     <= valid_s3;
			// Drop the position of an out-of-range id to zero
			x_pos_q <= valid_s3 ? xg[22:0] : '0;
			y_pos_q <= valid_s3 ? yg[22:0] : '0;
			z_pos_q <= valid_s3 ? phpd_pkg::Z_REF[mod_s3[3:0]][22:0] : '0;
		end
	end

	assign res_valid     = res_valid_q;
	assign partition     = partition_q;
	assign front_end     = front_end_q;
	assign module_index  = module_index_q;
	assign pixel_row     = pixel_row_q;
	assign module_column = module_column_q;
	assign x_pos         = x_pos_q;
	assign y_pos         = y_pos_q;
	assign z_pos         = z_pos_q;
	assign valid_res     = valid_res_q;

	// Checks
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !valid_res) |-> (x_pos == '0 && y_pos == '0 && z_pos == '0))
		else $error("invalid hit carries a nonzero position");

	a_valid_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && valid_res) |-> (pixel_row != 10'd0 && pixel_row <= ROWS_LIM &&
			5'(module_index) < MODS_LIM && partition != 2'd3))
		else $error("valid hit with a field out of range");

	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !rdy_out) |=> (v_s3 && $stable(col_s3) && $stable(mod_s3)))
		else $error("stage 3 lost its item while the output was stalled");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && res_valid_q && !res_ready) |-> !hit_ready)
		else $error("hit accepted while every stage is full and stalled");

endmodule

// ===== verif/pixel_hit_position_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the pixel hit position decoder. It watches the hit and result channels,
// predicts each result from the hit id and compares it field by field. No package needed.

module pixel_hit_position_checker #(
	parameter int NUM_MODULES   = 12,
	parameter int ROWS_PER_CHIP = 336,
	parameter int COLS_PER_CHIP = 80
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               hit_valid,
	input  logic               hit_ready,
	input  logic        [24:0] detector_id,
	input  logic               res_valid,
	input  logic               res_ready,
	input  logic        [1:0]  partition,
	input  logic        [2:0]  front_end,
	input  logic        [3:0]  module_index,
	input  logic        [9:0]  pixel_row,
	input  logic        [10:0] module_column,
	input  logic signed [22:0] x_pos,
	input  logic signed [22:0] y_pos,
	input  logic signed [22:0] z_pos,
	input  logic               valid_res,
	output int                 mismatch_count,
	output int                 pending_results
);

	typedef struct packed {
		logic [1:0]         partition;
		logic [2:0]         front_end;
		logic [3:0]         module_index;
		logic [9:0]         pixel_row;
		logic [10:0]        module_column;
		logic signed [22:0] x_pos;
		logic signed [22:0] y_pos;
		logic signed [22:0] z_pos;
		logic               valid_res;
	} hit_result_t;

	// Module alignment in units of 1e-5 cm; modules past the twelfth sit at zero
	localparam longint ALIGN_Z [16] = '{
		-13000, 52000, 241200, 309000, 510000, 579000,
		779000, 846000, 1046200, 1117000, 1316200, 1385000, 0, 0, 0, 0
	};
	localparam longint ALIGN_X [16] = '{
		69960, 60900, 69600, 69400, 68850, 59700,
		66200, 67100, 70400, 58950, 64550, 63200, 0, 0, 0, 0
	};
	localparam longint ALIGN_Y [16] = '{
		-150, 200, -4700, -5900, -3700, -6100,
		-12000, -8850, -7000, -6900, -7400, -4500, 0, 0, 0, 0
	};

	hit_result_t expected_results [$];
	hit_result_t want;
	int bad_fields = 0;

	// 1e-8 cm down to the nearest 1e-5 cm, ties toward plus infinity
	function automatic longint nearest_step(input longint v);
		longint t, q;
		t = v + 500;
		q = t / 1000;
		if (t % 1000 != 0 && t < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic hit_result_t decode_hit(input logic [24:0] id);
		hit_result_t res;
		longint idv, part, fe, row, col, mdl, xl, yl, gx, gy, x_align, y_align;
		logic in_range;
		int m;
		idv = longint'(id);
		part = idv / 10000000;
		fe = (idv % 10000000) / 1000000;
		row = (idv % 1000000) / 1000;
		col = idv % 1000;
		mdl = (8 * part + fe) / 2;
		in_range = part <= 2 && fe <= 7 && row >= 1 && row <= ROWS_PER_CHIP &&
			col >= 1 && col <= COLS_PER_CHIP && mdl < NUM_MODULES;
		res.partition = part[1:0];
		res.front_end = fe[2:0];
		res.module_index = mdl[3:0];
		res.pixel_row = row[9:0];
		res.module_column = 11'(col + ((fe % 2 == 0) ? COLS_PER_CHIP : 0));
		res.x_pos = '0;
		res.y_pos = '0;
		res.z_pos = '0;
		res.valid_res = in_range;
		if (in_range) begin
			m = int'(mdl % 16);
			// odd front ends count columns back from the edge
			if (fe % 2 == 1) begin
				xl = -2500 * (COLS_PER_CHIP - col);
				if (col == COLS_PER_CHIP)
					xl = xl - 2250;
			end else begin
				xl = 2250 + (col - 1) * 2500;
				if (col == COLS_PER_CHIP)
					xl = xl + 2500;
			end
			yl = 167750 - 500 * (row - 1);
			case (fe)
				0, 1: begin
					gx = -yl;
					gy = xl;
				end
				2, 3: begin
					gx = yl;
					gy = xl;
				end
				4, 5: begin
					gx = -xl;
					gy = -yl;
				end
				default: begin
					gx = -xl;
					gy = yl;
				end
			endcase
			x_align = ALIGN_X[m] * 1000 + ALIGN_Z[m] * 31 / 10;
			y_align = ALIGN_Y[m] * 1000 + ALIGN_Z[m] * 68 / 10;
			res.x_pos = 23'(nearest_step(gx * 1000 - x_align));
			res.y_pos = 23'(nearest_step(gy * 1000 - y_align));
			res.z_pos = 23'(ALIGN_Z[m]);
		end
		return res;
	endfunction

	// Report every bad field in full and count it
	task automatic compare_field(input string name, input longint exp_v, input longint got_v);
		if (exp_v != got_v) begin
			bad_fields++;
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (hit_valid && hit_ready)
				expected_results.push_back(decode_hit(detector_id));
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					bad_fields++;
					$display("%0t: result transfer expected none, got partition %0d row %0d",
						$time, partition, pixel_row);
				end else begin
					want = expected_results.pop_front();
					compare_field("partition", want.partition, partition);
					compare_field("front_end", want.front_end, front_end);
					compare_field("module_index", want.module_index, module_index);
					compare_field("pixel_row", want.pixel_row, pixel_row);
					compare_field("module_column", want.module_column, module_column);
					compare_field("x_pos", $signed(want.x_pos), x_pos);
					compare_field("y_pos", $signed(want.y_pos), y_pos);
					compare_field("z_pos", $signed(want.z_pos), z_pos);
					compare_field("valid_res", want.valid_res, valid_res);
				end
			end
			mismatch_count <= bad_fields;
			pending_results <= expected_results.size();
		end
	end

endmodule

// ===== verif/pixel_hit_position_decoder_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the pixel hit position decoder: clock, reset, hit stimulus and
// result back-pressure. Depends on pixel_hit_position_checker for prediction and compare.

module pixel_hit_position_decoder_test;

	// Roughly 1225 hits at one per cycle, slowed by 30% idling on both sides and
	// one long hold-off; the limit leaves a wide margin over that.
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_HITS = 1200;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [24:0] ID_MAX = 25'h1FFFFFF;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               hit_valid = 1'b0;
	logic               hit_ready;
	logic        [24:0] detector_id = '0;
	logic               res_valid;
	logic               res_ready = 1'b0;
	logic        [1:0]  partition;
	logic        [2:0]  front_end;
	logic        [3:0]  module_index;
	logic        [9:0]  pixel_row;
	logic        [10:0] module_column;
	logic signed [22:0] x_pos;
	logic signed [22:0] y_pos;
	logic signed [22:0] z_pos;
	logic               valid_res;
	int                 mismatch_count;
	int                 pending_results;
	int                 cycle_count = 0;
	int                 hits_sent = 0;

	pixel_hit_position_decoder uut (.*);

	pixel_hit_position_checker scoreboard (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Build a decimal-packed id; fields may be out of range on purpose
	function automatic logic [24:0] pack_hit_id(input int unsigned part, input int unsigned fe,
			input int unsigned row, input int unsigned col);
		return 25'(part * 10000000 + fe * 1000000 + row * 1000 + col);
	endfunction

	// Mostly well-formed hits with extra weight on the edge rows and columns, mixed at random
	// with hits that have one field pushed out of range and with raw 25-bit noise.
	function automatic logic [24:0] random_hit_id();
		int unsigned pick, part, fe, row, col;
		pick = $urandom_range(99);
		part = $urandom_range(2);
		fe = $urandom_range(7);
		case ($urandom_range(9))
			0: row = 1;
			1: row = 336;
			default: row = $urandom_range(336, 1);
		endcase
		case ($urandom_range(9))
			0: col = 1;
			1: col = 80;
			default: col = $urandom_range(80, 1);
		endcase
		if (pick >= 92)
			return 25'($urandom_range(ID_MAX));
		if (pick >= 80) begin
			case ($urandom_range(4))
				0: row = 0;
				1: row = $urandom_range(999, 337);
				2: col = 0;
				3: col = $urandom_range(999, 81);
				default: fe = $urandom_range(9, 8);
			endcase
		end
		return pack_hit_id(part, fe, row, col);
	endfunction

	// Offer one hit and hold it until the transfer. Idle ~30% of cycles before it, except
	// in a stretch of back-to-back hits. Lower valid only when a gap really follows.
	task automatic send_hit(input logic [24:0] id);
		int gap;
		gap = 0;
		if (hits_sent < 500 || hits_sent >= 800)
			while ($urandom_range(99) < 30)
				gap++;
		if (gap > 0) begin
			hit_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		hit_valid <= 1'b1;
		detector_id <= id;
		@(posedge clk);
		while (!hit_ready)
			@(posedge clk);
		hits_sent++;
	endtask

	// Result side: random ~30% stalls, one long hold-off so the pipeline fills up and
	// hit_ready drops while hits keep coming, then a stretch always ready.
	initial begin
		int ready_cycle;
		ready_cycle = 0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			@(posedge clk);
			ready_cycle++;
			if (ready_cycle >= 400 && ready_cycle < 650)
				res_ready <= 1'b0;
			else if (ready_cycle >= 1000 && ready_cycle < 1400)
				res_ready <= 1'b1;
			else
				res_ready <= ($urandom_range(99) >= 30);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("pixel_hit_position_decoder: mismatch");
			$finish;
		end
	end

	initial begin
		int n;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every front end orientation at the first pixel, spread over the partitions
		for (n = 0; n < 8; n++)
			send_hit(pack_hit_id(n % 3, n, 1, 1));
		// Edge column on both column parities, last row, near-edge column
		send_hit(pack_hit_id(1, 0, 336, 80));
		send_hit(pack_hit_id(2, 7, 336, 80));
		send_hit(pack_hit_id(2, 4, 168, 80));
		send_hit(pack_hit_id(1, 3, 2, 79));
		send_hit(pack_hit_id(0, 5, 336, 1));
		// Out-of-range fields: zero id, rows and columns just outside and far outside
		send_hit('0);
		send_hit(pack_hit_id(0, 2, 0, 40));
		send_hit(pack_hit_id(1, 6, 337, 40));
		send_hit(pack_hit_id(2, 1, 100, 0));
		send_hit(pack_hit_id(0, 3, 100, 81));
		send_hit(pack_hit_id(1, 1, 999, 999));
		// Partition out of range and front end too wide: the reported front end wraps, column keeps parity
		send_hit(pack_hit_id(3, 0, 1, 1));
		send_hit(pack_hit_id(0, 8, 1, 1));
		send_hit(pack_hit_id(2, 8, 1, 1));
		send_hit(pack_hit_id(2, 9, 999, 999));
		// Largest 25-bit id
		send_hit(ID_MAX);

		for (n = 0; n < RANDOM_HITS; n++)
			send_hit(random_hit_id());
		hit_valid <= 1'b0;

		// Let the last transfer reach the scoreboard, drain, then allow the pipeline depth
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_results == 0)
			$display("pixel_hit_position_decoder: match");
		else
			$display("pixel_hit_position_decoder: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
src/phpd_pkg.sv
src/pixel_hit_position_decoder.sv
verif/pixel_hit_position_checker.sv
verif/pixel_hit_position_decoder_test.sv
